@@ rtl/dbam_pkg.sv @@
// Shared types and constants for the disk block allocation map.
package dbam_pkg;

	typedef struct packed {
		logic [2:0]  kind;
		logic [6:0]  track;
		logic [5:0]  sector;
		logic [39:0] load_map;
		logic [7:0]  load_free;
	} item_t;

	typedef struct packed {
		logic [7:0]  alloc_track;
		logic [5:0]  alloc_sector;
		logic [14:0] free_total;
		logic [39:0] read_map;
		logic [7:0]  read_free;
	} result_t;

	localparam logic [2:0] KIND_LOAD  = 3'd0;
	localparam logic [2:0] KIND_READ  = 3'd1;
	localparam logic [2:0] KIND_USED  = 3'd2;
	localparam logic [2:0] KIND_FREE  = 3'd3;
	localparam logic [2:0] KIND_ALLOC = 3'd4;
	localparam logic [2:0] KIND_COUNT = 3'd5;

	localparam logic [7:0] NO_TRACK     = 8'hff;
	// Zero-based index of the directory track, left out of the free total.
	localparam logic [7:0] EXCL_TRK_IDX = 8'd39;

	// Memory requests carry the widest address and map the design allows.
	typedef struct packed {
		logic        rd_en;
		logic [7:0]  rd_addr;
		logic        wr_en;
		logic [7:0]  wr_addr;
		logic [63:0] wr_map;
		logic [7:0]  wr_cnt;
	} mem_req_t;

	typedef struct packed {
		logic [63:0] map;
		logic [7:0]  cnt;
	} mem_rsp_t;

endpackage

@@ rtl/disk_block_allocation_map.sv @@
// Disk block allocation map top level: free map and free count per track.
// Load writes its track when taken; read and mark read it, and mark writes it back;
// allocate stops at the first free sector, count scans all tracks (one track per cycle).
// One word is worked at a time; the next is taken once the result is registered.
// Reset clears per-track valid bits at once, so every track reads empty after reset.
module disk_block_allocation_map #(
	parameter int TRACKS            = 80,
	parameter int SECTORS_PER_TRACK = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dbam_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dbam_pkg::result_t result
);
	import dbam_pkg::*;

	mem_req_t req;
	mem_rsp_t rsp;

	dbam_ctrl #(
		.TRACKS            (TRACKS),
		.SECTORS_PER_TRACK (SECTORS_PER_TRACK)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.req          (req),
		.rsp          (rsp)
	);

	dbam_mem #(
		.TRACKS            (TRACKS),
		.SECTORS_PER_TRACK (SECTORS_PER_TRACK)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ rtl/dbam_mem.sv @@
// Track entry memory: one synchronous read port, one write port, valid bits.
module dbam_mem #(
	parameter int TRACKS            = 80,
	parameter int SECTORS_PER_TRACK = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dbam_pkg::mem_req_t req,
	output dbam_pkg::mem_rsp_t rsp
);
	import dbam_pkg::*;

	localparam int TW = $clog2(TRACKS);
	localparam int MW = SECTORS_PER_TRACK;

	logic [MW+7:0]     mem_q [TRACKS];
	logic [TRACKS-1:0] valid_q;
	logic [MW+7:0]     rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[TW-1:0]] <= {req.wr_map[MW-1:0], req.wr_cnt};
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr[TW-1:0]];
		end
	end

	// An entry never written since reset reads as an empty track.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr[TW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr[TW-1:0]];
			end
		end
	end

	assign rsp.map = rd_valid_q ? 64'(rd_data_q[MW+7:8]) : 64'd0;
	assign rsp.cnt = rd_valid_q ? rd_data_q[7:0] : 8'd0;

endmodule

@@ rtl/dbam_ctrl.sv @@
// Sequencer: decodes a word, walks the track memory and builds the result.
module dbam_ctrl #(
	parameter int TRACKS            = 80,
	parameter int SECTORS_PER_TRACK = 40
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  dbam_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output dbam_pkg::result_t  result,
	output dbam_pkg::mem_req_t req,
	input  dbam_pkg::mem_rsp_t rsp
);
	import dbam_pkg::*;

	localparam int TW = $clog2(TRACKS);

	typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_SCAN, ST_FIN} state_t;

	state_t        state_q;
	logic [2:0]    kind_q;
	logic [5:0]    sector_q;
	logic [7:0]    idx_q;
	logic [TW-1:0] rd_idx_q;
	logic          iss_q;
	logic          chk_vld_s1;
	logic [TW-1:0] chk_idx_s1;
	logic [14:0]   sum_q;
	result_t       res_q;
	result_t       result_q;
	logic          result_valid_q;

	logic          take;
	logic          trk_ok;
	logic          sec_ok;
	logic [7:0]    item_idx;
	logic          is_mark;
	logic          found;
	logic [5:0]    first_sec;
	logic          chk_last;
	logic [14:0]   sum_nxt;
	logic          out_free;

	// Lowest set bit of a track map.
	function automatic logic [5:0] first_set(input logic [63:0] map);
		logic [5:0] idx;
		idx = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (map[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

	assign take     = item_valid && (state_q == ST_IDLE);
	assign trk_ok   = (item.track != 7'd0) && ({1'b0, item.track} <= 8'(TRACKS));
	assign sec_ok   = {1'b0, item.sector} < 7'(SECTORS_PER_TRACK);
	assign item_idx = {1'b0, item.track} - 8'd1;
	assign is_mark  = (kind_q == KIND_USED) || (kind_q == KIND_FREE);
	assign found    = rsp.map != 64'd0;
	assign first_sec = first_set(rsp.map);
	assign chk_last = chk_idx_s1 == TW'(TRACKS - 1);
	assign sum_nxt  = (8'(chk_idx_s1) == EXCL_TRK_IDX) ? sum_q : sum_q + 15'(rsp.cnt);
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		req = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.rd_addr = item_idx;
				req.wr_addr = item_idx;
				req.wr_map  = 64'(item.load_map);
				req.wr_cnt  = item.load_free;
				if (take) begin
					req.wr_en = (item.kind == KIND_LOAD) && trk_ok;
					req.rd_en = ((item.kind == KIND_READ) && trk_ok) ||
						(((item.kind == KIND_USED) || (item.kind == KIND_FREE)) &&
						trk_ok && sec_ok);
				end
			end
			ST_RD: begin
				// Read-modify-write of a mark completes here.
				req.wr_en   = is_mark;
				req.wr_addr = idx_q;
				if (kind_q == KIND_USED) begin
					req.wr_map = rsp.map & ~(64'd1 << sector_q);
					req.wr_cnt = rsp.cnt - 8'd1;
				end else begin
					req.wr_map = rsp.map | (64'd1 << sector_q);
					req.wr_cnt = rsp.cnt + 8'd1;
				end
			end
			ST_SCAN: begin
				req.rd_en   = iss_q;
				req.rd_addr = 8'(rd_idx_q);
				req.wr_en   = chk_vld_s1 && (kind_q == KIND_ALLOC) && found;
				req.wr_addr = 8'(chk_idx_s1);
				req.wr_map  = rsp.map & ~(64'd1 << first_sec);
				req.wr_cnt  = rsp.cnt - 8'd1;
			end
			ST_FIN: begin
				req = '0;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			kind_q         <= KIND_LOAD;
			sector_q       <= '0;
			idx_q          <= '0;
			rd_idx_q       <= '0;
			iss_q          <= 1'b0;
			chk_vld_s1     <= 1'b0;
			chk_idx_s1     <= '0;
			sum_q          <= '0;
			res_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// The scan issues one read a cycle and checks the previous one.
			chk_vld_s1 <= req.rd_en && (state_q == ST_SCAN);
			chk_idx_s1 <= rd_idx_q;
			if (!(state_q == ST_FIN && out_free) && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						kind_q   <= item.kind;
						sector_q <= item.sector;
						idx_q    <= item_idx;
						rd_idx_q <= '0;
						sum_q    <= '0;
						res_q    <= '0;
						iss_q    <= (item.kind == KIND_ALLOC) || (item.kind == KIND_COUNT);
						priority if (req.rd_en) begin
							state_q <= ST_RD;
						end else if ((item.kind == KIND_ALLOC) ||
							(item.kind == KIND_COUNT)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: begin
					if (kind_q == KIND_READ) begin
						res_q.read_map  <= 40'(rsp.map);
						res_q.read_free <= rsp.cnt;
					end
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					if (iss_q) begin
						rd_idx_q <= rd_idx_q + TW'(1);
						if (rd_idx_q == TW'(TRACKS - 1)) begin
							iss_q <= 1'b0;
						end
					end
					if (chk_vld_s1) begin
						if (kind_q == KIND_ALLOC) begin
							// Reads still issued after a hit are dropped once the scan ends.
							priority if (found) begin
								res_q.alloc_track  <= 8'(chk_idx_s1) + 8'd1;
								res_q.alloc_sector <= first_sec;
								state_q            <= ST_FIN;
							end else if (chk_last) begin
								res_q.alloc_track  <= NO_TRACK;
								res_q.alloc_sector <= 6'd0;
								state_q            <= ST_FIN;
							end
						end else begin
							sum_q <= sum_nxt;
							if (chk_last) begin
								res_q.free_total <= sum_nxt;
								state_q          <= ST_FIN;
							end
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						result_q       <= res_q;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> (req.wr_addr < 8'(TRACKS)))
		else $error("track memory written beyond the last track");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en |-> (req.rd_addr < 8'(TRACKS)))
		else $error("track memory read beyond the last track");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result presented without a finished word");

	a_miss_sector: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.alloc_track == NO_TRACK) && (TRACKS < 255))
		|-> (result_q.alloc_sector == 6'd0))
		else $error("failed allocation returned a nonzero sector");

	a_no_write_and_read_in_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> !req.rd_en)
		else $error("read issued while a modify is being written back");

endmodule

@@ verif/tb_disk_block_allocation_map.sv @@
// Self-checking testbench for the disk block allocation map, with its own map predictor.
module tb_disk_block_allocation_map;
	import dbam_pkg::*;

	localparam int N_TRACKS     = 80;
	localparam int N_SECTORS    = 40;
	localparam int RANDOM_WORDS = 700;
	localparam int CYCLE_LIMIT  = 1000000;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Predicted disk state, one entry per track.
	logic [N_SECTORS-1:0] free_map [N_TRACKS] = '{default: '0};
	logic [7:0]           free_cnt [N_TRACKS] = '{default: '0};

	result_t pending_results [$];
	int      errors      = 0;
	int      cycle_count = 0;
	int      burst_left  = 1;
	int      stall_mode  = 0;
	int      stall_left  = 0;

	disk_block_allocation_map #(
		.TRACKS(N_TRACKS),
		.SECTORS_PER_TRACK(N_SECTORS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_disk_block_allocation_map: done, errors");
			$finish;
		end
	end

	// The receiver switches at random between four stall patterns.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 2) == 0);
			2: result_stall <= ((cycle_count % 7) < 3);
			default: result_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Applies one word to the predicted map and returns the result it should give.
	function automatic result_t apply_to_map(item_t w);
		result_t     r;
		logic        trk_ok;
		logic        found;
		int          idx;
		int          tt;
		int          ss;
		int          ft;
		int          fs;
		int unsigned sum;
		r      = '0;
		trk_ok = (w.track >= 1) && (w.track <= N_TRACKS);
		idx    = int'(w.track) - 1;
		case (w.kind)
			KIND_LOAD: begin
				if (trk_ok) begin
					free_map[idx] = w.load_map[N_SECTORS-1:0];
					free_cnt[idx] = w.load_free;
				end
			end
			KIND_READ: begin
				if (trk_ok) begin
					r.read_map  = 40'(free_map[idx]);
					r.read_free = free_cnt[idx];
				end
			end
			KIND_USED, KIND_FREE: begin
				if (trk_ok && w.sector < N_SECTORS) begin
					if (w.kind == KIND_USED) begin
						free_map[idx][w.sector] = 1'b0;
						free_cnt[idx]           = free_cnt[idx] - 8'd1;
					end else begin
						free_map[idx][w.sector] = 1'b1;
						free_cnt[idx]           = free_cnt[idx] + 8'd1;
					end
				end
			end
			KIND_ALLOC: begin
				found = 1'b0;
				ft    = 0;
				fs    = 0;
				for (tt = 0; tt < N_TRACKS && !found; tt++) begin
					for (ss = 0; ss < N_SECTORS && !found; ss++) begin
						if (free_map[tt][ss]) begin
							found = 1'b1;
							ft    = tt;
							fs    = ss;
						end
					end
				end
				if (found) begin
					free_map[ft][fs] = 1'b0;
					free_cnt[ft]     = free_cnt[ft] - 8'd1;
					r.alloc_track    = 8'(ft + 1);
					r.alloc_sector   = 6'(fs);
				end else begin
					r.alloc_track  = NO_TRACK;
					r.alloc_sector = '0;
				end
			end
			KIND_COUNT: begin
				sum = 0;
				for (tt = 0; tt < N_TRACKS; tt++) begin
					if (tt != EXCL_TRK_IDX)
						sum += free_cnt[tt];
				end
				r.free_total = 15'(sum);
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int field_differs(string name, logic [39:0] exp_v, logic [39:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin : check_results
		result_t exp_r;
		int      bad;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word arrived with nothing expected");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				bad   = field_differs("alloc_track", exp_r.alloc_track, result.alloc_track);
				bad  += field_differs("alloc_sector", exp_r.alloc_sector, result.alloc_sector);
				bad  += field_differs("free_total", exp_r.free_total, result.free_total);
				bad  += field_differs("read_map", exp_r.read_map, result.read_map);
				bad  += field_differs("read_free", exp_r.read_free, result.read_free);
				errors += bad;
			end
		end
	end

	function automatic item_t make_word(logic [2:0] kind, logic [6:0] track, logic [5:0] sector,
			logic [39:0] map, logic [7:0] cnt);
		item_t w;
		w.kind      = kind;
		w.track     = track;
		w.sector    = sector;
		w.load_map  = map;
		w.load_free = cnt;
		return w;
	endfunction

	// Offers one word, holds it until accepted, then maybe leaves a gap.
	task automatic send_word(item_t w);
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		pending_results.push_back(apply_to_map(w));
		burst_left--;
		if (burst_left <= 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (N_TRACKS + 8) @(posedge clk);
	endtask

	task automatic test_after_reset();
		send_word(make_word(KIND_READ, 7'd1, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd80, 6'd0, '0, '0));
		send_word(make_word(KIND_ALLOC, 7'd0, 6'd0, '0, '0));
		send_word(make_word(KIND_COUNT, 7'd0, 6'd0, '0, '0));
	endtask

	task automatic test_load_and_read();
		send_word(make_word(KIND_LOAD, 7'd1, 6'd0, 40'hff_ffff_ffff, 8'hff));
		send_word(make_word(KIND_LOAD, 7'd80, 6'd0, 40'h80_0000_0001, 8'd2));
		send_word(make_word(KIND_LOAD, 7'd40, 6'd0, 40'h55_5555_5555, 8'd200));
		// Out-of-range tracks must leave every entry alone.
		send_word(make_word(KIND_LOAD, 7'd0, 6'd0, 40'hff_ffff_ffff, 8'hff));
		send_word(make_word(KIND_LOAD, 7'd127, 6'd63, 40'hff_ffff_ffff, 8'hff));
		send_word(make_word(KIND_READ, 7'd1, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd40, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd0, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd127, 6'd0, '0, '0));
	endtask

	task automatic test_mark_sectors();
		send_word(make_word(KIND_USED, 7'd1, 6'd39, '0, '0));
		// Marking a sector that is already used still lowers the count.
		send_word(make_word(KIND_USED, 7'd1, 6'd39, '0, '0));
		// Track 2 holds a count of zero, so this wraps to 255.
		send_word(make_word(KIND_USED, 7'd2, 6'd5, '0, '0));
		send_word(make_word(KIND_FREE, 7'd2, 6'd63, '0, '0));
		send_word(make_word(KIND_USED, 7'd0, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd1, 6'd0, '0, '0));
		send_word(make_word(KIND_READ, 7'd2, 6'd0, '0, '0));
	endtask

	task automatic test_alloc_and_count();
		send_word(make_word(KIND_COUNT, 7'd0, 6'd0, '0, '0));
		send_word(make_word(KIND_ALLOC, 7'd0, 6'd0, '0, '0));
	endtask

	task automatic test_unused_kinds();
		send_word(make_word(3'd6, 7'd1, 6'd0, 40'hff_ffff_ffff, 8'hff));
		send_word(make_word(3'd7, 7'h7f, 6'h3f, 40'hff_ffff_ffff, 8'hff));
		send_word(make_word(KIND_READ, 7'd1, 6'd0, '0, '0));
	endtask

	task automatic test_random_traffic();
		item_t w;
		int    useful;
		int    pick;
		int    tt;
		useful = 0;
		while (useful < RANDOM_WORDS) begin
			w.kind      = 3'($urandom_range(0, 5));
			w.track     = 7'($urandom_range(1, N_TRACKS));
			w.sector    = 6'($urandom_range(0, N_SECTORS - 1));
			w.load_map  = {8'($urandom), 32'($urandom)};
			w.load_free = 8'($urandom);
			pick        = $urandom_range(0, 99);
			if (pick < 10) begin
				// Noise: words that the block must ignore or answer with zeros.
				case ($urandom_range(0, 2))
					0: w.track = ($urandom_range(0, 1) == 0) ? 7'd0
						: 7'($urandom_range(N_TRACKS + 1, 127));
					1: begin
						w.kind   = ($urandom_range(0, 1) == 0) ? KIND_USED : KIND_FREE;
						w.sector = 6'($urandom_range(N_SECTORS, 63));
					end
					default: w.kind = 3'($urandom_range(6, 7));
				endcase
			end else if (pick == 10) begin
				// Clear the whole disk so that allocation can run dry.
				for (tt = 1; tt <= N_TRACKS; tt++)
					send_word(make_word(KIND_LOAD, 7'(tt), 6'($urandom), '0, 8'($urandom)));
				useful += N_TRACKS;
				continue;
			end else begin
				if ($urandom_range(0, 3) == 0)
					w.track = 7'($urandom_range(60, N_TRACKS));
				if (w.kind == KIND_LOAD) begin
					// Mostly sparse maps, so that allocation has to search far.
					case ($urandom_range(0, 3))
						0, 1: w.load_map = '0;
						2: w.load_map = 40'd1 << $urandom_range(0, N_SECTORS - 1);
						default: ;
					endcase
				end
			end
			send_word(w);
			if (w.kind <= KIND_COUNT && (w.kind >= KIND_ALLOC ||
					(w.track >= 1 && w.track <= N_TRACKS &&
					(w.kind <= KIND_READ || w.sector < N_SECTORS))))
				useful++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_load_and_read();
		test_mark_sectors();
		test_alloc_and_count();
		test_unused_kinds();
		wait_idle();
		test_random_traffic();
		wait_idle();
		if (errors == 0)
			$display("tb_disk_block_allocation_map: done, clean");
		else
			$display("tb_disk_block_allocation_map: done, errors");
		$finish;
	end

endmodule

@@ disk_block_allocation_map.f @@
rtl/dbam_pkg.sv
rtl/dbam_mem.sv
rtl/dbam_ctrl.sv
rtl/disk_block_allocation_map.sv
verif/tb_disk_block_allocation_map.sv
